// ===== hdl/stwe_pkg.sv =====
// ----------------------------------------------------------------------------
// stwe_pkg
// shared types and constants for the sliding time window extremes block
// ----------------------------------------------------------------------------
package stwe_pkg;

    localparam int RING_DEPTH_DEF  = 1024;
    localparam int TIME_BITS_DEF   = 32;

    localparam int WIN_BITS        = 16;
    localparam int IN_TIME_BITS    = 32;
    localparam int OUT_TIME_BITS   = 32;
    localparam int COUNT_BITS      = 11;

    localparam logic [WIN_BITS-1:0] WIN_RESET = 16'd2;

    // one input request
    typedef struct packed {
        logic [IN_TIME_BITS-1:0] event_time;
        logic                    last_event;
    } t_in;

    // one result
    typedef struct packed {
        logic [COUNT_BITS-1:0]    max_count;
        logic [OUT_TIME_BITS-1:0] max_first_time;
        logic [OUT_TIME_BITS-1:0] max_last_time;
        logic [COUNT_BITS-1:0]    min_count;
        logic [OUT_TIME_BITS-1:0] min_first_time;
        logic [OUT_TIME_BITS-1:0] min_last_time;
        logic                     overflow;
    } t_out;

endpackage

// ===== hdl/stwe_front.sv =====
// ----------------------------------------------------------------------------
// stwe_front
// accepts input requests, fits the time to the internal width, and holds
// them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module stwe_front #(
    parameter int TIME_BITS = stwe_pkg::TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stwe_pkg::t_in      i_in_data,
    output logic               o_job_valid,
    output logic [TIME_BITS:0] o_job_data,
    input  logic               i_job_pop
);

    localparam int EXT_W = (TIME_BITS > stwe_pkg::IN_TIME_BITS) ?
                           TIME_BITS : stwe_pkg::IN_TIME_BITS;

    logic [TIME_BITS:0] r_q_data [2];
    logic               r_wr_ptr, n_wr_ptr;
    logic               r_rd_ptr, n_rd_ptr;
    logic [1:0]         r_cnt, n_cnt;

    logic               push;
    logic               pop;
    logic [EXT_W-1:0]   time_ext;

    // zero-extend or cut the incoming time to the internal width
    assign time_ext    = EXT_W'(i_in_data.event_time);

    assign o_in_stall  = (r_cnt == 2'd2);
    assign push        = i_in_valid & ~o_in_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = i_job_pop & o_job_valid;
    assign o_job_data  = r_q_data[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_cnt    = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_data[r_wr_ptr] <= {i_in_data.last_event, time_ext[TIME_BITS-1:0]};
        end
    end

endmodule

// ===== hdl/stwe_back.sv =====
// ----------------------------------------------------------------------------
// stwe_back
// ring buffer sequencer: retires expired entries, stores new times, tracks
// the busiest and quietest window and drives the result register
// ----------------------------------------------------------------------------
module stwe_back #(
    parameter int RING_DEPTH = stwe_pkg::RING_DEPTH_DEF,
    parameter int TIME_BITS  = stwe_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [stwe_pkg::WIN_BITS-1:0] i_window,
    input  logic                          i_job_valid,
    input  logic [TIME_BITS:0]            i_job_data,
    output logic                          o_job_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output stwe_pkg::t_out                o_out_data
);

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int CEXT_W = (CNT_W > stwe_pkg::COUNT_BITS) ? CNT_W : stwe_pkg::COUNT_BITS;
    localparam int TEXT_W = (TIME_BITS > stwe_pkg::OUT_TIME_BITS) ?
                            TIME_BITS : stwe_pkg::OUT_TIME_BITS;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [TIME_BITS-1:0] mem [RING_DEPTH];
    logic [TIME_BITS-1:0] r_rd_data;

    logic [2:0]           r_state, n_state;
    logic [TIME_BITS-1:0] r_t, n_t;
    logic                 r_last, n_last;
    logic                 r_first_byp, n_first_byp;
    logic [IDX_W-1:0]     r_head, n_head;
    logic [IDX_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_occ, n_occ;
    logic [TIME_BITS-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]     r_max, n_max;
    logic [TIME_BITS-1:0] r_max_first, n_max_first;
    logic [TIME_BITS-1:0] r_max_last, n_max_last;
    logic [CNT_W-1:0]     r_min, n_min;
    logic                 r_min_set, n_min_set;
    logic [TIME_BITS-1:0] r_min_first, n_min_first;
    logic [TIME_BITS-1:0] r_min_last, n_min_last;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid, n_out_valid;
    stwe_pkg::t_out       r_out, n_out;

    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [TIME_BITS-1:0] win_ext;
    logic [TIME_BITS-1:0] age;
    logic                 expire;
    logic                 full;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_next;
    logic [IDX_W-1:0]     push_head;
    logic [CNT_W-1:0]     push_occ;
    logic                 close_en;
    logic [CNT_W-1:0]     close_cnt;
    logic [TIME_BITS-1:0] close_first;
    logic [TIME_BITS-1:0] close_last;
    logic                 out_free;
    logic [CEXT_W-1:0]    max_cnt_ext, min_cnt_ext;
    logic [TEXT_W-1:0]    max_first_ext, max_last_ext, min_first_ext, min_last_ext;

    assign win_ext   = TIME_BITS'(i_window);
    assign age       = r_t - r_rd_data;
    assign expire    = (r_t > r_rd_data) && (age > win_ext);
    assign full      = (r_occ == FULL_CNT);
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    // a full ring drops its oldest entry without closing a window
    assign push_head = full ? head_next : r_head;
    assign push_occ  = full ? r_occ - 1'b1 : r_occ;
    assign out_free  = ~r_out_valid | ~i_out_stall;

    assign max_cnt_ext   = CEXT_W'(r_max);
    assign min_cnt_ext   = CEXT_W'(r_min);
    assign max_first_ext = TEXT_W'(r_max_first);
    assign max_last_ext  = TEXT_W'(r_max_last);
    assign min_first_ext = TEXT_W'(r_min_first);
    assign min_last_ext  = TEXT_W'(r_min_last);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_last      = r_last;
        n_first_byp = r_first_byp;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_prev      = r_prev;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        o_job_pop   = 1'b0;
        rd_addr     = r_head;
        wr_en       = 1'b0;
        close_en    = 1'b0;
        close_cnt   = r_occ;
        close_first = r_rd_data;
        close_last  = r_prev;

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_t       = i_job_data[TIME_BITS-1:0];
                    n_last    = i_job_data[TIME_BITS];
                    n_state   = (r_occ == '0) ? S_PUSH : S_CMP;
                end
            end
            S_CMP, S_PUSH: begin
                if (r_state == S_CMP && expire) begin
                    // close the window that starts at the oldest entry
                    close_en = 1'b1;
                    n_head   = head_next;
                    n_occ    = r_occ - 1'b1;
                    rd_addr  = head_next;
                    if (r_occ == CNT_W'(1)) begin
                        n_state = S_PUSH;
                    end
                end else begin
                    wr_en       = 1'b1;
                    n_ovf       = r_ovf | full;
                    n_head      = push_head;
                    n_tail      = tail_next;
                    n_occ       = push_occ + 1'b1;
                    n_prev      = r_t;
                    rd_addr     = push_head;
                    // oldest entry is the one written now when the ring was empty
                    n_first_byp = (push_occ == '0);
                    n_state     = r_last ? S_LAST : S_IDLE;
                end
            end
            S_LAST: begin
                close_en    = 1'b1;
                close_first = r_first_byp ? r_t : r_rd_data;
                close_last  = r_t;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.max_count      = max_cnt_ext[stwe_pkg::COUNT_BITS-1:0];
                    n_out.max_first_time = max_first_ext[stwe_pkg::OUT_TIME_BITS-1:0];
                    n_out.max_last_time  = max_last_ext[stwe_pkg::OUT_TIME_BITS-1:0];
                    n_out.min_count      = min_cnt_ext[stwe_pkg::COUNT_BITS-1:0];
                    n_out.min_first_time = min_first_ext[stwe_pkg::OUT_TIME_BITS-1:0];
                    n_out.min_last_time  = min_last_ext[stwe_pkg::OUT_TIME_BITS-1:0];
                    n_out.overflow       = r_ovf;
                    n_head               = '0;
                    n_tail               = '0;
                    n_occ                = '0;
                    n_prev               = '0;
                    n_ovf                = 1'b0;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // running extremes: strict compare keeps the earliest window on a tie
    always_comb begin
        n_max       = r_max;
        n_max_first = r_max_first;
        n_max_last  = r_max_last;
        n_min       = r_min;
        n_min_set   = r_min_set;
        n_min_first = r_min_first;
        n_min_last  = r_min_last;
        if (r_state == S_EMIT && out_free) begin
            n_max       = '0;
            n_max_first = '0;
            n_max_last  = '0;
            n_min       = '1;
            n_min_set   = 1'b0;
            n_min_first = '0;
            n_min_last  = '0;
        end else if (close_en) begin
            if (close_cnt > r_max) begin
                n_max       = close_cnt;
                n_max_first = close_first;
                n_max_last  = close_last;
            end
            if (!r_min_set || close_cnt < r_min) begin
                n_min       = close_cnt;
                n_min_set   = 1'b1;
                n_min_first = close_first;
                n_min_last  = close_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_prev      <= '0;
            r_max       <= '0;
            r_max_first <= '0;
            r_max_last  <= '0;
            r_min       <= '1;
            r_min_set   <= 1'b0;
            r_min_first <= '0;
            r_min_last  <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_prev      <= n_prev;
            r_max       <= n_max;
            r_max_first <= n_max_first;
            r_max_last  <= n_max_last;
            r_min       <= n_min;
            r_min_set   <= n_min_set;
            r_min_first <= n_min_first;
            r_min_last  <= n_min_last;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_first_byp <= n_first_byp;
        r_out       <= n_out;
    end

    // time ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= r_t;
        end
        r_rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/sliding_time_window_extremes.sv =====
// ----------------------------------------------------------------------------
// sliding_time_window_extremes
// busiest and quietest time window over a stream of event timestamps
// ----------------------------------------------------------------------------
// Timestamps arrive one per request, non-decreasing within a stream, and are
// kept in a ring of RING_DEPTH entries. An entry expires when a new time is
// more than window_seconds past it; each expiry closes the window that starts
// at that entry and updates the busiest (strictly greater count) and quietest
// (strictly smaller count) windows. The request flagged last_event also closes
// the window at the current oldest entry and produces the one result of the
// stream, after which the block starts a fresh stream (window_seconds stays).
// A full ring drops its oldest entry silently and raises overflow. For each
// timestamp the back end sequencer takes the request while idle, retires the
// expired entries one at a time, then stores the new time; the last request of
// a stream then closes the final window and loads the result register, waiting
// while a held result is still stalled. The ring memory has one read port with
// a registered output, so the sequencer looks at one oldest entry per cycle. A
// two-entry request queue lets the input side keep taking requests while the
// sequencer works, and the result register holds a finished result while the
// next stream is already being taken in. No clearing pass runs after reset:
// only occupied ring entries are ever read.
// ----------------------------------------------------------------------------
module sliding_time_window_extremes #(
    parameter int RING_DEPTH = stwe_pkg::RING_DEPTH_DEF,
    parameter int TIME_BITS  = stwe_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: window_seconds
    input  logic                          i_cfg_we,
    input  logic [stwe_pkg::WIN_BITS-1:0] i_cfg_wdata,
    // input requests
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  stwe_pkg::t_in                 i_in_data,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output stwe_pkg::t_out                o_out_data
);

    // window length register; the user must write it only while the block is idle (not enforced here)
    logic [stwe_pkg::WIN_BITS-1:0] r_window;

    // queue between front and back
    logic               job_valid;
    logic [TIME_BITS:0] job_data;
    logic               job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= stwe_pkg::WIN_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // front end: takes requests and buffers them
    stwe_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .o_job_data  (job_data),
        .i_job_pop   (job_pop)
    );

    // back end: ring buffer walk, window extremes and result register
    stwe_back #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window    (r_window),
        .i_job_valid (job_valid),
        .i_job_data  (job_data),
        .o_job_pop   (job_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
